// File: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked on every rising clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/osrw_pkg.sv
// Shared types, codes and constants for the reply window timer.
// Used by osrw_step and one_shot_reply_window_timer; depends on nothing.
`default_nettype none

package osrw_pkg;

  // Operation codes carried in the input word's user field.
  typedef enum logic [2:0] {
    OP_QUERY    = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_START    = 3'd2,
    OP_EXPIRE   = 3'd3,
    OP_CANCEL   = 3'd4
  } op_e;

  // Configuration register indexes.
  localparam int unsigned CfgAddrWidth = 2;
  localparam logic [CfgAddrWidth-1:0] REG_MAX_OPEN_DELAY = 2'd0;
  localparam logic [CfgAddrWidth-1:0] REG_MIN_WINDOW     = 2'd1;
  localparam logic [CfgAddrWidth-1:0] REG_MAX_WINDOW     = 2'd2;

  // Register reset values, milliseconds.
  localparam logic [31:0] MaxOpenDelayReset = 32'd2000;
  localparam logic [31:0] MinWindowReset    = 32'd1000;
  localparam logic [31:0] MaxWindowReset    = 32'd30000;

  // Packed word widths.
  localparam int unsigned InDataWidth  = 128;
  localparam int unsigned InUserWidth  = 3;
  localparam int unsigned OutDataWidth = 200;

  typedef struct packed {
    logic [31:0] max_open_delay;
    logic [31:0] min_window;
    logic [31:0] max_window;
  } osrw_cfg_t;

  // Slot and counter state.
  typedef struct packed {
    logic        armed;
    logic [31:0] slot_tag;
    logic [31:0] opens_at;
    logic [31:0] expires_at;
    logic [31:0] request_cnt;
    logic [31:0] reject_cnt;
    logic [31:0] start_cnt;
    logic [31:0] expire_cnt;
    logic [31:0] cancel_cnt;
  } osrw_state_t;

  // One result word before packing.
  typedef struct packed {
    logic        ok;
    logic        is_due;
    logic        is_expired;
    logic        is_pending;
    logic [31:0] held_tag;
    logic [31:0] request_count;
    logic [31:0] reject_count;
    logic [31:0] start_count;
    logic [31:0] expire_count;
    logic [31:0] cancel_count;
  } osrw_result_t;

  // A time t is reached when the wrapping difference now - t is not negative.
  function automatic logic reached(logic [31:0] now, logic [31:0] t);
    logic [31:0] diff;
    diff = now - t;
    return ~diff[31];
  endfunction

endpackage

`default_nettype wire

// File: rtl/osrw_step.sv
// Combinational step of the reply window timer: next slot state and result word.
// Depends on osrw_pkg.
`default_nettype none

module osrw_step (
  input  wire logic [2:0]           op_i,
  input  wire logic [31:0]          now_ms_i,
  input  wire logic [31:0]          tag_i,
  input  wire logic [31:0]          open_after_i,
  input  wire logic [31:0]          window_len_i,
  input  wire osrw_pkg::osrw_cfg_t   cfg_i,
  input  wire osrw_pkg::osrw_state_t state_i,
  output osrw_pkg::osrw_state_t      state_o,
  output osrw_pkg::osrw_result_t     result_o
);

  logic        exp_old;
  logic        due_old;
  logic        sched_bad;
  logic [31:0] opens_new;
  logic [31:0] win_end;
  logic [31:0] neg_open;
  logic [31:0] neg_end;
  logic        exp_new;
  logic        due_new;
  logic        ok;
  logic        due_after;
  logic        exp_after;
  osrw_pkg::osrw_state_t st_d;

  // Window status of the current slot at this word's time.
  assign exp_old = state_i.armed && osrw_pkg::reached(now_ms_i, state_i.expires_at);
  assign due_old = state_i.armed && osrw_pkg::reached(now_ms_i, state_i.opens_at) && !exp_old;

  // Schedule checks and the new window. The wrapping differences now - opens_at
  // and now - expires_at of the new window are -open_after and -(open_after + window_len).
  assign sched_bad = state_i.armed || (tag_i == 32'd0) ||
                     (open_after_i > cfg_i.max_open_delay) ||
                     (window_len_i < cfg_i.min_window) ||
                     (window_len_i > cfg_i.max_window);
  assign opens_new = now_ms_i + open_after_i;
  assign win_end   = open_after_i + window_len_i;
  assign neg_open  = 32'd0 - open_after_i;
  assign neg_end   = 32'd0 - win_end;
  assign exp_new   = ~neg_end[31];
  assign due_new   = ~neg_open[31] && !exp_new;

  // Apply the operation.
  always_comb begin
    st_d      = state_i;
    ok        = 1'b0;
    due_after = due_old;
    exp_after = exp_old;
    case (osrw_pkg::op_e'(op_i))
      osrw_pkg::OP_SCHEDULE: begin
        st_d.request_cnt = state_i.request_cnt + 32'd1;
        if (sched_bad) begin
          st_d.reject_cnt = state_i.reject_cnt + 32'd1;
        end else begin
          st_d.armed      = 1'b1;
          st_d.slot_tag   = tag_i;
          st_d.opens_at   = opens_new;
          st_d.expires_at = opens_new + window_len_i;
          ok              = 1'b1;
          due_after       = due_new;
          exp_after       = exp_new;
        end
      end
      osrw_pkg::OP_START: begin
        if (due_old) begin
          st_d.start_cnt  = state_i.start_cnt + 32'd1;
          st_d.armed      = 1'b0;
          st_d.slot_tag   = 32'd0;
          st_d.opens_at   = 32'd0;
          st_d.expires_at = 32'd0;
          ok              = 1'b1;
          due_after       = 1'b0;
          exp_after       = 1'b0;
        end
      end
      osrw_pkg::OP_EXPIRE: begin
        if (exp_old) begin
          st_d.expire_cnt = state_i.expire_cnt + 32'd1;
          st_d.armed      = 1'b0;
          st_d.slot_tag   = 32'd0;
          st_d.opens_at   = 32'd0;
          st_d.expires_at = 32'd0;
          ok              = 1'b1;
          due_after       = 1'b0;
          exp_after       = 1'b0;
        end
      end
      osrw_pkg::OP_CANCEL: begin
        if (state_i.armed) begin
          st_d.cancel_cnt = state_i.cancel_cnt + 32'd1;
        end
        st_d.armed      = 1'b0;
        st_d.slot_tag   = 32'd0;
        st_d.opens_at   = 32'd0;
        st_d.expires_at = 32'd0;
        due_after       = 1'b0;
        exp_after       = 1'b0;
      end
      default: begin
        // Query and unused codes leave everything as it is.
      end
    endcase
  end

  assign state_o = st_d;

  // Result word reflects the state after the step.
  assign result_o.ok            = ok;
  assign result_o.is_due        = due_after;
  assign result_o.is_expired    = exp_after;
  assign result_o.is_pending    = st_d.armed;
  assign result_o.held_tag      = st_d.slot_tag;
  assign result_o.request_count = st_d.request_cnt;
  assign result_o.reject_count  = st_d.reject_cnt;
  assign result_o.start_count   = st_d.start_cnt;
  assign result_o.expire_count  = st_d.expire_cnt;
  assign result_o.cancel_count  = st_d.cancel_cnt;

endmodule

`default_nettype wire

// File: rtl/one_shot_reply_window_timer.sv
// One-shot reply window timer with a single slot. Each input word carries an
// operation (query, schedule, start, expire, cancel) and the current time; each
// gives exactly one result word with the slot flags and counters after the step.
// Words are registered on entry, stepped through one short combinational pass
// and captured in an output register, so a new word is taken every clock
// cycle when the output side is not stalled; its result word is presented
// from the output register once the step has been captured there.
// The slot state register is the only loop, closed once per word.
// Configuration registers may be written only while the block is idle.
// Depends on osrw_pkg, osrw_step and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module one_shot_reply_window_timer (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [osrw_pkg::CfgAddrWidth-1:0]     cfg_addr_i,
  input  wire logic [31:0]                           cfg_wdata_i,
  // Input word stream.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: now_ms[31:0], tag[63:32], open_after[95:64], window_len[127:96]
  input  wire logic [osrw_pkg::InDataWidth-1:0]      s_axis_tdata,
  // tuser: operation[2:0]
  input  wire logic [osrw_pkg::InUserWidth-1:0]      s_axis_tuser,
  // Result word stream.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // tdata: ok[0], is_due[1], is_expired[2], is_pending[3], held_tag[35:4],
  // request_count[67:36], reject_count[99:68], start_count[131:100],
  // expire_count[163:132], cancel_count[195:164], zero fill[199:196]
  output logic [osrw_pkg::OutDataWidth-1:0]          m_axis_tdata
);

  osrw_pkg::osrw_cfg_t    cfg_q;
  osrw_pkg::osrw_state_t  state_q;
  osrw_pkg::osrw_state_t  state_d;
  osrw_pkg::osrw_result_t result_d;
  osrw_pkg::osrw_result_t result_q;

  logic                               in_valid_q;
  logic [osrw_pkg::InUserWidth-1:0]   in_op_q;
  logic [osrw_pkg::InDataWidth-1:0]   in_data_q;
  logic                               out_valid_q;
  logic                               out_free;
  logic                               advance;
  logic                               in_accept;

  // Handshake: the input register moves on when the output register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_open_delay <= osrw_pkg::MaxOpenDelayReset;
      cfg_q.min_window     <= osrw_pkg::MinWindowReset;
      cfg_q.max_window     <= osrw_pkg::MaxWindowReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        osrw_pkg::REG_MAX_OPEN_DELAY: cfg_q.max_open_delay <= cfg_wdata_i;
        osrw_pkg::REG_MIN_WINDOW:     cfg_q.min_window     <= cfg_wdata_i;
        osrw_pkg::REG_MAX_WINDOW:     cfg_q.max_window     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Step logic.
  osrw_step u_step (
    .op_i         (in_op_q),
    .now_ms_i     (in_data_q[31:0]),
    .tag_i        (in_data_q[63:32]),
    .open_after_i (in_data_q[95:64]),
    .window_len_i (in_data_q[127:96]),
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // Slot state advances once per word that moves to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          result_q.cancel_count,
                          result_q.expire_count,
                          result_q.start_count,
                          result_q.reject_count,
                          result_q.request_count,
                          result_q.held_tag,
                          result_q.is_pending,
                          result_q.is_expired,
                          result_q.is_due,
                          result_q.ok};

  // An armed slot always holds a nonzero tag, and a free slot holds zero.
  `ASSERT_CLK(a_armed_tag, state_q.armed == (state_q.slot_tag != 32'd0), "armed/tag mismatch")
  // A result is never due and expired at once.
  `ASSERT_IMPL(a_due_xor_exp, m_axis_tvalid, !(result_q.is_due && result_q.is_expired), "due+exp")
  // Due or expired results only come from a pending slot.
  `ASSERT_IMPL(a_flag_pending,
               m_axis_tvalid && (result_q.is_due || result_q.is_expired),
               result_q.is_pending, "flag without pending slot")
  // Input is held off only while a word waits in the input register.
  `ASSERT_IMPL(a_ready_hold, !s_axis_tready, in_valid_q && out_valid_q, "ready low, no backlog")

endmodule

`default_nettype wire

// File: test/one_shot_reply_window_timer_tb.sv
// Self-checking testbench for the one-shot reply window timer.
// It predicts each result word from its own copy of the slot, counters and
// registers. It depends on osrw_pkg and on the one_shot_reply_window_timer RTL.
`default_nettype none

module one_shot_reply_window_timer_tb;

  // Register index beyond the last register; writes to it are ignored.
  localparam logic [osrw_pkg::CfgAddrWidth-1:0] REG_NONE = 2'd3;
  // Operation codes with no meaning; the block treats them as a query.
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  // Spare cycles after the last result word.
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RunLimit = 4_000_000;
  localparam int unsigned MaxReports = 10;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   cfg_we_i = 1'b0;
  logic [osrw_pkg::CfgAddrWidth-1:0]      cfg_addr_i = '0;
  logic [31:0]                            cfg_wdata_i = '0;
  logic                                   s_axis_tvalid = 1'b0;
  logic                                   s_axis_tready;
  logic [osrw_pkg::InDataWidth-1:0]       s_axis_tdata = '0;
  logic [osrw_pkg::InUserWidth-1:0]       s_axis_tuser = '0;
  logic                                   m_axis_tvalid;
  logic                                   m_axis_tready = 1'b0;
  logic [osrw_pkg::OutDataWidth-1:0]      m_axis_tdata;

  // Predicted block state and register copies.
  osrw_pkg::osrw_state_t  slot = '0;
  osrw_pkg::osrw_cfg_t    window_cfg = '{osrw_pkg::MaxOpenDelayReset,
                                         osrw_pkg::MinWindowReset,
                                         osrw_pkg::MaxWindowReset};
  osrw_pkg::osrw_result_t expected_q[$];

  int unsigned errors = 0;
  int unsigned result_idx = 0;
  int unsigned sink_hold = 0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  logic [31:0] now_cursor = '0;

  one_shot_reply_window_timer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // A time is reached once the wrapping difference to it is not negative.
  function automatic logic time_reached(logic [31:0] now, logic [31:0] mark);
    logic [31:0] diff;
    diff = now - mark;
    return ~diff[31];
  endfunction

  function automatic logic window_expired(logic [31:0] now);
    return slot.armed && time_reached(now, slot.expires_at);
  endfunction

  function automatic logic window_due(logic [31:0] now);
    return slot.armed && time_reached(now, slot.opens_at) && !window_expired(now);
  endfunction

  function automatic void clear_slot();
    slot.armed      = 1'b0;
    slot.slot_tag   = '0;
    slot.opens_at   = '0;
    slot.expires_at = '0;
  endfunction

  // Advance the predicted slot by one input word and return its result word.
  function automatic osrw_pkg::osrw_result_t step_window(logic [2:0] op, logic [31:0] now,
                                                         logic [31:0] tag,
                                                         logic [31:0] delay,
                                                         logic [31:0] wlen);
    osrw_pkg::osrw_result_t res;
    res = '0;
    case (op)
      osrw_pkg::OP_SCHEDULE: begin
        slot.request_cnt = slot.request_cnt + 32'd1;
        if (slot.armed || tag == '0 || delay > window_cfg.max_open_delay ||
            wlen < window_cfg.min_window || wlen > window_cfg.max_window) begin
          slot.reject_cnt = slot.reject_cnt + 32'd1;
        end else begin
          slot.armed      = 1'b1;
          slot.slot_tag   = tag;
          slot.opens_at   = now + delay;
          slot.expires_at = slot.opens_at + wlen;
          res.ok          = 1'b1;
        end
      end
      osrw_pkg::OP_START: begin
        if (window_due(now)) begin
          slot.start_cnt = slot.start_cnt + 32'd1;
          clear_slot();
          res.ok = 1'b1;
        end
      end
      osrw_pkg::OP_EXPIRE: begin
        if (window_expired(now)) begin
          slot.expire_cnt = slot.expire_cnt + 32'd1;
          clear_slot();
          res.ok = 1'b1;
        end
      end
      osrw_pkg::OP_CANCEL: begin
        if (slot.armed) begin
          slot.cancel_cnt = slot.cancel_cnt + 32'd1;
        end
        clear_slot();
      end
      default: begin
      end
    endcase
    res.is_due        = window_due(now);
    res.is_expired    = window_expired(now);
    res.is_pending    = slot.armed;
    res.held_tag      = slot.slot_tag;
    res.request_count = slot.request_cnt;
    res.reject_count  = slot.reject_cnt;
    res.start_count   = slot.start_cnt;
    res.expire_count  = slot.expire_cnt;
    res.cancel_count  = slot.cancel_cnt;
    return res;
  endfunction

  // Offer one input word, with an occasional idle gap, and record its result.
  task automatic send_word(logic [2:0] op, logic [31:0] now, logic [31:0] tag,
                           logic [31:0] delay, logic [31:0] wlen);
    if (src_idle && $urandom_range(3, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wlen, delay, tag, now};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(step_window(op, now, tag, delay, wlen));
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding result word come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One register write; the predictor copy changes only for known indexes.
  task automatic write_reg(logic [osrw_pkg::CfgAddrWidth-1:0] addr, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      osrw_pkg::REG_MAX_OPEN_DELAY: window_cfg.max_open_delay = value;
      osrw_pkg::REG_MIN_WINDOW:     window_cfg.min_window = value;
      osrw_pkg::REG_MAX_WINDOW:     window_cfg.max_window = value;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic [31:0] delay_max, logic [31:0] wmin, logic [31:0] wmax);
    wait_idle();
    write_reg(osrw_pkg::REG_MAX_OPEN_DELAY, delay_max);
    write_reg(REG_NONE, $urandom());
    write_reg(osrw_pkg::REG_MIN_WINDOW, wmin);
    write_reg(osrw_pkg::REG_MAX_WINDOW, wmax);
  endtask

  // Mostly well-formed schedule, start, expire, query and cancel sequences, plus noise.
  task automatic random_traffic(int unsigned count, bit with_idle);
    logic [2:0]  op;
    logic [31:0] now;
    logic [31:0] tag;
    logic [31:0] delay;
    logic [31:0] wlen;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        src_idle  = with_idle && $urandom_range(2, 0) != 0;
        sink_idle = with_idle && $urandom_range(2, 0) != 0;
      end
      now = now_cursor + $urandom_range(3000, 0);
      tag = ($urandom_range(9, 0) == 0) ? '0 : $urandom();
      case ($urandom_range(9, 0))
        0: delay = window_cfg.max_open_delay;
        1: delay = window_cfg.max_open_delay + 32'd1;
        2: delay = $urandom();
        default: delay = $urandom_range(window_cfg.max_open_delay, 0);
      endcase
      case ($urandom_range(9, 0))
        0: wlen = window_cfg.min_window;
        1: wlen = window_cfg.max_window;
        2: wlen = window_cfg.min_window - 32'd1;
        3: wlen = window_cfg.max_window + 32'd1;
        4: wlen = $urandom();
        default: wlen = $urandom_range(window_cfg.max_window, window_cfg.min_window);
      endcase
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        // Noise: any code, any field values.
        op    = 3'($urandom_range(OP_RESERVED_HI, osrw_pkg::OP_QUERY));
        now   = $urandom();
        tag   = $urandom();
        delay = $urandom();
        wlen  = $urandom();
      end else if (!slot.armed) begin
        op = (roll < 75) ? osrw_pkg::OP_SCHEDULE :
             3'($urandom_range(osrw_pkg::OP_CANCEL, osrw_pkg::OP_QUERY));
      end else begin
        // Armed: aim at the edges of the window.
        case ($urandom_range(7, 0))
          0: now = slot.opens_at - 32'd1;
          1: now = slot.opens_at;
          2: now = slot.expires_at - 32'd1;
          3: now = slot.expires_at;
          4: now = slot.expires_at + $urandom_range(5000, 1);
          5: now = slot.opens_at + $urandom_range(slot.expires_at - slot.opens_at, 0);
          6: now = slot.opens_at - $urandom_range(5000, 2);
          default: now = now_cursor;
        endcase
        roll = $urandom_range(99, 0);
        if (roll < 30) begin
          op = osrw_pkg::OP_START;
        end else if (roll < 60) begin
          op = osrw_pkg::OP_EXPIRE;
        end else if (roll < 75) begin
          op = osrw_pkg::OP_QUERY;
        end else if (roll < 88) begin
          op = osrw_pkg::OP_CANCEL;
        end else begin
          op = osrw_pkg::OP_SCHEDULE;
        end
      end
      send_word(op, now, tag, delay, wlen);
      now_cursor = now;
    end
  endtask

  // Reset register values: field limits, every operation and both wraps.
  task automatic test_reset_defaults();
    send_word(osrw_pkg::OP_QUERY, 32'd0, '0, '0, '0);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, '0, 32'd10, 32'd1000);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, 32'd9,
              osrw_pkg::MaxOpenDelayReset + 32'd1, 32'd1000);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, 32'd9, 32'd0,
              osrw_pkg::MinWindowReset - 32'd1);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, 32'd9, 32'd0,
              osrw_pkg::MaxWindowReset + 32'd1);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, '1, '1, '1);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd100, '1, osrw_pkg::MaxOpenDelayReset,
              osrw_pkg::MinWindowReset);
    // A schedule while armed is rejected and leaves the slot alone.
    send_word(osrw_pkg::OP_SCHEDULE, 32'd200, 32'd7, 32'd0, 32'd5000);
    send_word(osrw_pkg::OP_START, 32'd2099, '0, '0, '0);
    send_word(osrw_pkg::OP_EXPIRE, 32'd3099, '0, '0, '0);
    send_word(osrw_pkg::OP_QUERY, 32'd2100, '0, '0, '0);
    send_word(osrw_pkg::OP_START, 32'd2100, '0, '0, '0);
    // Cancel on a free slot leaves the cancel counter alone.
    send_word(osrw_pkg::OP_CANCEL, 32'd2200, '0, '0, '0);
    // Window that wraps through zero.
    send_word(osrw_pkg::OP_SCHEDULE, 32'hFFFF_F000, 32'd5, 32'd0, osrw_pkg::MaxWindowReset);
    send_word(OP_RESERVED_LO, 32'h0000_0010, '1, '1, '1);
    send_word(osrw_pkg::OP_START, 32'hFFFF_EFFF, '0, '0, '0);
    send_word(OP_RESERVED_HI, 32'h0000_6530, '0, '0, '0);
    send_word(osrw_pkg::OP_START, 32'h0000_6530, '0, '0, '0);
    send_word(osrw_pkg::OP_EXPIRE, 32'h0000_6530, '0, '0, '0);
    // Half a wrap away the expiry already counts as reached.
    send_word(osrw_pkg::OP_SCHEDULE, 32'h8000_0000, 32'h8000_0001, 32'd0, 32'd1000);
    send_word(osrw_pkg::OP_QUERY, 32'd0, '0, '0, '0);
    send_word(osrw_pkg::OP_CANCEL, 32'd0, '0, '0, '0);
  endtask

  // Register extremes, an ignored index and crossed window limits.
  task automatic test_config_extremes();
    wait_idle();
    write_reg(osrw_pkg::REG_MAX_OPEN_DELAY, '1);
    write_reg(osrw_pkg::REG_MIN_WINDOW, '0);
    write_reg(osrw_pkg::REG_MAX_WINDOW, '1);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd50, 32'd3, '1, '1);
    send_word(osrw_pkg::OP_QUERY, 32'd49, '0, '0, '0);
    send_word(osrw_pkg::OP_CANCEL, 32'd49, '0, '0, '0);
    // A zero-length window is expired as soon as it opens.
    send_word(osrw_pkg::OP_SCHEDULE, 32'd60, 32'd4, 32'd0, 32'd0);
    send_word(osrw_pkg::OP_EXPIRE, 32'd60, '0, '0, '0);
    wait_idle();
    write_reg(REG_NONE, '0);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd70, 32'd6, 32'hFFFF_FFFE, 32'd5);
    send_word(osrw_pkg::OP_CANCEL, 32'd70, '0, '0, '0);
    wait_idle();
    write_reg(osrw_pkg::REG_MIN_WINDOW, 32'd10);
    write_reg(osrw_pkg::REG_MAX_WINDOW, 32'd5);
    send_word(osrw_pkg::OP_SCHEDULE, 32'd80, 32'd6, 32'd0, 32'd7);
    now_cursor = 32'd80;
  endtask

  // Random traffic under several register settings.
  task automatic test_random_traffic();
    apply_config(osrw_pkg::MaxOpenDelayReset, osrw_pkg::MinWindowReset,
                 osrw_pkg::MaxWindowReset);
    random_traffic(120, 1'b1);
    apply_config($urandom_range(50, 0), $urandom_range(20, 0), $urandom_range(100, 20));
    random_traffic(120, 1'b1);
    apply_config($urandom(), $urandom(), $urandom());
    random_traffic(120, 1'b1);
    apply_config('1, '0, '1);
    random_traffic(120, 1'b1);
  endtask

  // Back-to-back words with both sides always ready.
  task automatic test_steady_stream();
    apply_config($urandom_range(5000, 0), $urandom_range(500, 0), $urandom_range(60000, 500));
    random_traffic(120, 1'b0);
  endtask

  // Receiver side: while sink_idle is set, ready drops in random bursts of random length.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(5, 0) == 0) begin
      sink_hold     <= $urandom_range(10, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic note_failure(string what);
    errors++;
    if (errors <= MaxReports) begin
      $display("result word %0d: %s", result_idx, what);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s expected %h, got %h", name, want, got));
    end
  endtask

  // Compare each result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    osrw_pkg::osrw_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = expected_q.pop_front();
        check_field("ok", 32'(want.ok), 32'(m_axis_tdata[0]));
        check_field("is_due", 32'(want.is_due), 32'(m_axis_tdata[1]));
        check_field("is_expired", 32'(want.is_expired), 32'(m_axis_tdata[2]));
        check_field("is_pending", 32'(want.is_pending), 32'(m_axis_tdata[3]));
        check_field("held_tag", want.held_tag, m_axis_tdata[35:4]);
        check_field("request_count", want.request_count, m_axis_tdata[67:36]);
        check_field("reject_count", want.reject_count, m_axis_tdata[99:68]);
        check_field("start_count", want.start_count, m_axis_tdata[131:100]);
        check_field("expire_count", want.expire_count, m_axis_tdata[163:132]);
        check_field("cancel_count", want.cancel_count, m_axis_tdata[195:164]);
        check_field("zero fill", '0, 32'(m_axis_tdata[199:196]));
      end
      result_idx++;
    end
  end

  // Test sequence.
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    test_steady_stream();
    wait_idle();
    if (errors == 0) begin
      $display("one_shot_reply_window_timer: match");
    end else begin
      $display("one_shot_reply_window_timer: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #RunLimit;
    $display("one_shot_reply_window_timer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
